@@ hw/rtl/qyh_pkg.sv @@
// ---------------------------------------------------------------------------
// Quaternion to yaw and heading: shared package
// Payload types, fixed-point widths, constants and the CORDIC angle table
// used by every stage of the yaw and heading pipeline.
// ---------------------------------------------------------------------------
package qyh_pkg;

  // Field widths of the transactions.
  localparam int unsigned IdW   = 8;
  localparam int unsigned QuatW = 16;
  localparam int unsigned YawW  = 16;
  localparam int unsigned HeadW = 16;

  // Internal widths: products, vector components, Q24 angle, magnitude, wrapped
  // angle, and the scaled heading numerator.
  localparam int unsigned ProdW = 32;
  localparam int unsigned XW    = 38;
  localparam int unsigned ZW    = 28;
  localparam int unsigned MW    = 33;
  localparam int unsigned ZzW   = 27;
  localparam int unsigned NW    = 42;

  // CORDIC table length and default number of iterations.
  localparam int unsigned TableLen           = 24;
  localparam int unsigned CordicStepsDefault = 16;

  // Only rotation vector reports produce a result.
  localparam logic [IdW-1:0] RotationReport = 8'h08;

  // Angle constants in Q24 radians.
  localparam longint PiQ24L = 52707179;
  localparam logic signed [ZW-1:0] PiQ24 = ZW'(PiQ24L);

  // Yaw is the Q24 angle rounded half up to Q13.
  localparam int unsigned YawShift = 11;
  localparam logic signed [ZW-1:0] YawHalf = ZW'(1024);
  localparam logic signed [YawW-1:0] YawMax = 16'sd25736;

  // Heading in 1/128 degree: round(zz * 23040 / pi). The quotient is first
  // estimated with a fixed-point reciprocal, then corrected by one step.
  localparam int unsigned HeadShift = 32;
  localparam int unsigned HeadScaleW = 22;
  localparam longint HeadScaleL = (longint'(23040) << HeadShift) / PiQ24L;
  localparam longint HeadBiasL  = ((PiQ24L / 2) << HeadShift) / PiQ24L;
  localparam logic [HeadScaleW-1:0] HeadScale = HeadScaleW'(HeadScaleL);
  localparam logic [HeadShift-1:0]  HeadBias  = HeadShift'(HeadBiasL);
  localparam logic [14:0]           HeadPerPi = 15'd23040;
  localparam logic [NW-1:0]         PiWide    = NW'(PiQ24L);
  localparam logic [NW-1:0]         RoundBias = NW'(PiQ24L / 2);
  localparam logic [HeadW-1:0]      HeadingFull = 16'd46080;

  // Input transaction.
  typedef struct packed {
    logic        [IdW-1:0]   report_id;
    logic signed [QuatW-1:0] quat_i;
    logic signed [QuatW-1:0] quat_j;
    logic signed [QuatW-1:0] quat_k;
    logic signed [QuatW-1:0] quat_real;
  } in_t;

  // Output transaction.
  typedef struct packed {
    logic signed [YawW-1:0]  yaw_radians;
    logic        [HeadW-1:0] heading_degrees;
  } out_t;

  // Vector and angle state passed between pipeline sections.
  typedef struct packed {
    logic              zero;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  // atan(2^-idx) in Q24 radians, rounded.
  function automatic logic [ZW-1:0] atan_q24(input int idx);
    logic [ZW-1:0] val;
    unique case (idx)
      0:       val = ZW'(13176795);
      1:       val = ZW'(7778716);
      2:       val = ZW'(4110060);
      3:       val = ZW'(2086331);
      4:       val = ZW'(1047214);
      5:       val = ZW'(524117);
      6:       val = ZW'(262123);
      7:       val = ZW'(131069);
      8:       val = ZW'(65536);
      9:       val = ZW'(32768);
      10:      val = ZW'(16384);
      11:      val = ZW'(8192);
      12:      val = ZW'(4096);
      13:      val = ZW'(2048);
      14:      val = ZW'(1024);
      15:      val = ZW'(512);
      16:      val = ZW'(256);
      17:      val = ZW'(128);
      18:      val = ZW'(64);
      19:      val = ZW'(32);
      20:      val = ZW'(16);
      21:      val = ZW'(8);
      22:      val = ZW'(4);
      23:      val = ZW'(2);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

@@ hw/rtl/quaternion_to_yaw_heading_top.sv @@
// ---------------------------------------------------------------------------
// Quaternion to yaw and heading: top level
// Converts rotation vector reports into yaw (Q13 radians) and heading
// (1/128 degree, [0, 360)) through a fully pipelined vectoring CORDIC.
// ---------------------------------------------------------------------------
// The block accepts one report per clock cycle and never stalls on its own.
// Each report with id 8 yields exactly one result transaction; any other id is
// accepted and dropped. From acceptance to the output port, each report passes
// through these stages (CORDIC_STEPS is capped at 24): three stages build the
// vector, seven normalize it, one stage per CORDIC iteration follows, six
// stages scale the angle, and one output register feeds the port. When the
// output is held off, a skid register absorbs one result and the whole
// pipeline then freezes until the output drains, so in_ready_o is a register.
module quaternion_to_yaw_heading_top
  import qyh_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CordicStepsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic    en;
  logic    vec_in_valid;
  logic    vec_valid, norm_valid, cordic_valid, post_valid;
  cordic_t vec_data, norm_data, cordic_data;
  out_t    post_data;

  logic out_valid_d, out_valid_q;
  logic skid_valid_d, skid_valid_q;
  logic load_out_pipe, load_out_skid, load_skid;
  logic push, pop;
  out_t out_data_q, skid_data_q;

  // The pipeline advances whenever the skid register is free.
  assign en           = !skid_valid_q;
  assign in_ready_o   = en;
  assign vec_in_valid = in_valid_i && en && (in_data_i.report_id == RotationReport);

  qyh_vec u_vec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vec_in_valid),
    .data_i  (in_data_i),
    .valid_o (vec_valid),
    .data_o  (vec_data)
  );

  qyh_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vec_valid),
    .data_i  (vec_data),
    .valid_o (norm_valid),
    .data_o  (norm_data)
  );

  qyh_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (norm_valid),
    .data_i  (norm_data),
    .valid_o (cordic_valid),
    .data_o  (cordic_data)
  );

  qyh_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cordic_valid),
    .data_i  (cordic_data),
    .valid_o (post_valid),
    .data_o  (post_data)
  );

  // Output register with a one-entry skid buffer behind it.
  assign push = post_valid && en;
  assign pop  = out_valid_q && out_ready_i;

  always_comb begin
    out_valid_d   = out_valid_q;
    skid_valid_d  = skid_valid_q;
    load_out_pipe = 1'b0;
    load_out_skid = 1'b0;
    load_skid     = 1'b0;
    if (skid_valid_q) begin
      if (pop) begin
        load_out_skid = 1'b1;
        skid_valid_d  = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        load_out_pipe = 1'b1;
        out_valid_d   = 1'b1;
      end else begin
        load_skid    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out_pipe) begin
      out_data_q <= post_data;
    end else if (load_out_skid) begin
      out_data_q <= skid_data_q;
    end
    if (load_skid) begin
      skid_data_q <= post_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The skid register only holds a result behind a waiting output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while output register is empty");

  // The skid register only fills when the output was stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !out_ready_i))
    else $error("skid register filled without an output stall");

  // Heading stays below a full turn.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.heading_degrees < HeadingFull))
    else $error("heading out of range");

  // Yaw stays within [-pi, pi] in Q13.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(out_data_o.yaw_radians) <= YawMax &&
                     $signed(out_data_o.yaw_radians) >= -YawMax))
    else $error("yaw out of range");

endmodule

@@ hw/rtl/qyh_vec.sv @@
// ---------------------------------------------------------------------------
// Quaternion to yaw and heading: vector front end
// Forms Y = 2(ij + rk) and X = r*r + i*i - j*j - k*k exactly, then folds a
// left half-plane vector into the right half-plane with a start angle of +/-pi.
// ---------------------------------------------------------------------------
module qyh_vec
  import qyh_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    valid_i,
  input  in_t     data_i,
  output logic    valid_o,
  output cordic_t data_o
);

  logic [2:0] vld_q;

  logic signed [ProdW-1:0] p_ij_q, p_rk_q, p_rr_q, p_ii_q, p_jj_q, p_kk_q;
  logic signed [XW-1:0]    vx_q, vy_q;
  cordic_t                 rot_d, rot_q;

  // Valid bits advance with the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  // Stage 1: the six products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_ij_q <= data_i.quat_i * data_i.quat_j;
      p_rk_q <= data_i.quat_real * data_i.quat_k;
      p_rr_q <= data_i.quat_real * data_i.quat_real;
      p_ii_q <= data_i.quat_i * data_i.quat_i;
      p_jj_q <= data_i.quat_j * data_i.quat_j;
      p_kk_q <= data_i.quat_k * data_i.quat_k;
    end
  end

  // Stage 2: vector components.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vx_q <= XW'(p_rr_q) + XW'(p_ii_q) - XW'(p_jj_q) - XW'(p_kk_q);
      vy_q <= (XW'(p_ij_q) + XW'(p_rk_q)) <<< 1;
    end
  end

  // Stage 3: half-plane fold and start angle.
  always_comb begin
    rot_d.zero = (vx_q == '0) && (vy_q == '0);
    if (vx_q < 0) begin
      rot_d.x = -vx_q;
      rot_d.y = -vy_q;
      rot_d.z = (vy_q >= 0) ? PiQ24 : -PiQ24;
    end else begin
      rot_d.x = vx_q;
      rot_d.y = vy_q;
      rot_d.z = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q <= rot_d;
    end
  end

  assign valid_o = vld_q[2];
  assign data_o  = rot_q;

endmodule

@@ hw/rtl/qyh_norm.sv @@
// ---------------------------------------------------------------------------
// Quaternion to yaw and heading: vector normalizer
// Scales the vector by the largest power of two that keeps max(x, |y|) below
// 2^33, so that it lands in [2^32, 2^33). One binary search step per stage.
// ---------------------------------------------------------------------------
module qyh_norm
  import qyh_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    valid_i,
  input  cordic_t data_i,
  output logic    valid_o,
  output cordic_t data_o
);

  // Shifts of 32, 16, 8, 4, 2 and 1 cover every magnitude from 1 upward.
  localparam int unsigned NormSteps = $clog2(MW);

  typedef struct packed {
    cordic_t          v;
    logic [MW-1:0]    m;
  } nrm_t;

  logic [NormSteps:0] vld_q;

  logic signed [XW-1:0] abs_y;
  logic        [MW-1:0] mag_d;
  nrm_t                 mag_q;
  nrm_t                 src [NormSteps];
  nrm_t                 nxt [NormSteps];
  nrm_t                 sh_q [NormSteps];

  // Valid bits advance with the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NormSteps-1:0], valid_i};
    end
  end

  // Entry stage: magnitude bound max(x, |y|); x is never negative here.
  always_comb begin
    abs_y = data_i.y[XW-1] ? -data_i.y : data_i.y;
    mag_d = (data_i.x > abs_y) ? MW'(data_i.x) : MW'(abs_y);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q.v <= data_i;
      mag_q.m <= mag_d;
    end
  end

  // Search stages: shift when the scaled magnitude still fits below 2^MW.
  always_comb begin
    int unsigned sh;
    src[0] = mag_q;
    for (int s = 1; s < NormSteps; s++) begin
      src[s] = sh_q[s-1];
    end
    for (int s = 0; s < NormSteps; s++) begin
      sh = (1 << (NormSteps - 1)) >> s;
      nxt[s] = src[s];
      if ((src[s].m >> (MW - sh)) == '0) begin
        nxt[s].m   = src[s].m << sh;
        nxt[s].v.x = src[s].v.x <<< sh;
        nxt[s].v.y = src[s].v.y <<< sh;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NormSteps; s++) begin
        sh_q[s] <= nxt[s];
      end
    end
  end

  assign valid_o = vld_q[NormSteps];
  assign data_o  = sh_q[NormSteps-1].v;

endmodule

@@ hw/rtl/qyh_cordic.sv @@
// ---------------------------------------------------------------------------
// Quaternion to yaw and heading: vectoring CORDIC
// One micro-rotation per stage. Each stage drives y toward zero and adds or
// subtracts atan(2^-i) to the Q24 angle accumulator.
// ---------------------------------------------------------------------------
module qyh_cordic
  import qyh_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CordicStepsDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    valid_i,
  input  cordic_t data_i,
  output logic    valid_o,
  output cordic_t data_o
);

  // The angle table bounds the number of useful iterations.
  localparam int unsigned NumSteps =
    (CORDIC_STEPS < TableLen) ? CORDIC_STEPS : TableLen;

  logic [NumSteps-1:0] vld_q;

  cordic_t src  [NumSteps];
  cordic_t nxt  [NumSteps];
  cordic_t st_q [NumSteps];

  // Valid bits advance with the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NumSteps-2:0], valid_i};
    end
  end

  // Micro-rotations: clockwise while y is not negative.
  always_comb begin
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    src[0] = data_i;
    for (int s = 1; s < NumSteps; s++) begin
      src[s] = st_q[s-1];
    end
    for (int s = 0; s < NumSteps; s++) begin
      xs = src[s].x >>> s;
      ys = src[s].y >>> s;
      nxt[s].zero = src[s].zero;
      if (!src[s].y[XW-1]) begin
        nxt[s].x = src[s].x + ys;
        nxt[s].y = src[s].y - xs;
        nxt[s].z = src[s].z + $signed(atan_q24(s));
      end else begin
        nxt[s].x = src[s].x - ys;
        nxt[s].y = src[s].y + xs;
        nxt[s].z = src[s].z - $signed(atan_q24(s));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NumSteps; s++) begin
        st_q[s] <= nxt[s];
      end
    end
  end

  assign valid_o = vld_q[NumSteps-1];
  assign data_o  = st_q[NumSteps-1];

endmodule

@@ hw/rtl/qyh_post.sv @@
// ---------------------------------------------------------------------------
// Quaternion to yaw and heading: output scaling
// Clamps the Q24 angle to [-pi, pi], rounds it to Q13 yaw, and converts it to
// a heading in 1/128 degree with a reciprocal estimate and one correction.
// ---------------------------------------------------------------------------
module qyh_post
  import qyh_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    valid_i,
  input  cordic_t data_i,
  output logic    valid_o,
  output out_t    data_o
);

  localparam int unsigned KProdW = ZzW + HeadScaleW;

  logic [5:0] vld_q;

  logic signed [ZW-1:0]   zc_d, zc_q;
  logic signed [ZW-1:0]   yaw_sum;
  logic signed [YawW-1:0] yaw2_q, yaw3_q, yaw4_q, yaw5_q;
  logic        [ZzW-1:0]  zz_q;
  logic        [KProdW-1:0] kprod;
  logic        [HeadW-1:0]  qest3_q, qest4_q, q5_q;
  logic        [NW-1:0]     n3_q, n4_q, qp4_q, rem;
  logic        [HeadW-1:0]  q_d, head_d;
  out_t                     out_q;

  // Valid bits advance with the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  // Stage 1: clamp to [-pi, pi]; a zero vector gives a zero angle.
  always_comb begin
    if (data_i.zero) begin
      zc_d = '0;
    end else if (data_i.z > PiQ24) begin
      zc_d = PiQ24;
    end else if (data_i.z < -PiQ24) begin
      zc_d = -PiQ24;
    end else begin
      zc_d = data_i.z;
    end
  end

  // Stage 2 logic: rounded yaw.
  assign yaw_sum = zc_q + YawHalf;

  // Stage 3 logic: reciprocal estimate of the heading and exact numerator.
  assign kprod = KProdW'(zz_q) * KProdW'(HeadScale) + KProdW'(HeadBias);

  // Stage 5 logic: one correction step on the estimate.
  assign rem = n4_q - qp4_q;
  assign q_d = qest4_q + HeadW'(rem >= PiWide);

  // Stage 6 logic: a heading of a full turn wraps to zero.
  assign head_d = (q5_q >= HeadingFull) ? q5_q - HeadingFull : q5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zc_q    <= zc_d;
      yaw2_q  <= YawW'(yaw_sum >>> YawShift);
      zz_q    <= ZzW'((zc_q < 0) ? zc_q + (PiQ24 <<< 1) : zc_q);
      qest3_q <= kprod[HeadShift +: HeadW];
      n3_q    <= NW'(zz_q) * NW'(HeadPerPi) + RoundBias;
      yaw3_q  <= yaw2_q;
      qest4_q <= qest3_q;
      n4_q    <= n3_q;
      qp4_q   <= NW'(qest3_q) * PiWide;
      yaw4_q  <= yaw3_q;
      q5_q    <= q_d;
      yaw5_q  <= yaw4_q;
      out_q.yaw_radians     <= yaw5_q;
      out_q.heading_degrees <= head_d;
    end
  end

  assign valid_o = vld_q[5];
  assign data_o  = out_q;

endmodule

@@ tb/sv/tb_top.sv @@
// ---------------------------------------------------------------------------
// Quaternion to yaw and heading: testbench
// Sends rotation reports and other reports through the block. Each accepted
// report with id 8 is run through a bit-exact CORDIC predictor. Each result
// transaction is checked against the oldest expected yaw and heading. The run
// covers phases with no idling, sender gaps, receiver stalls, both, and a
// full drain of the pipeline.
// ---------------------------------------------------------------------------
module tb_top;
  import qyh_pkg::*;

  localparam int unsigned CordicSteps = CordicStepsDefault;
  localparam int unsigned UsedSteps   = (CordicSteps > TableLen) ? TableLen : CordicSteps;
  localparam int unsigned Latency     = UsedSteps + 17;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned PhaseItems  = 220;
  localparam int unsigned MaxReports  = 10;

  // Constants of the angle computation; PiRad is in Q24 radians.
  localparam longint PiRad      = 52707179;
  localparam longint MagFloor   = 64'sd4294967296;
  localparam longint HeadPerPi  = 23040;
  localparam longint HeadWrap   = 46080;
  localparam int     MaxDoubles = 40;

  // atan(2^-n) in Q24 radians, rounded.
  localparam longint AtanTable [TableLen] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  bit          watchdog_on;
  out_t        expected_results [$];

  quaternion_to_yaw_heading_top #(
    .CORDIC_STEPS(CordicSteps)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Clock with a period of 4.
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Yaw and heading of one rotation report, bit for bit.
  function automatic out_t yaw_heading_of(in_t rpt);
    longint qi, qj, qk, qr;
    longint vx, vy, x, y, z, mag, xs, ys, yaw, zz, head;
    out_t   res;
    qi = longint'(rpt.quat_i);
    qj = longint'(rpt.quat_j);
    qk = longint'(rpt.quat_k);
    qr = longint'(rpt.quat_real);
    vy = 2 * (qi * qj + qr * qk);
    vx = qr * qr + qi * qi - qj * qj - qk * qk;
    res = '0;
    if (vx == 0 && vy == 0) begin
      return res;
    end
    // Fold the left half-plane onto the right one, starting from +/- pi.
    x = vx;
    y = vy;
    z = 0;
    if (vx < 0) begin
      x = -vx;
      y = -vy;
      z = (vy >= 0) ? PiRad : -PiRad;
    end
    // Normalize the vector so that its larger component reaches 2^32.
    mag = (y < 0) ? -y : y;
    if (x > mag) begin
      mag = x;
    end
    for (int n = 0; n < MaxDoubles && mag < MagFloor; n++) begin
      x = x * 2;
      y = y * 2;
      mag = mag * 2;
    end
    // Vectoring iterations; arithmetic shifts round toward minus infinity.
    for (int n = 0; n < UsedSteps; n++) begin
      xs = x >>> n;
      ys = y >>> n;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + AtanTable[n];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - AtanTable[n];
      end
    end
    if (z > PiRad) begin
      z = PiRad;
    end
    if (z < -PiRad) begin
      z = -PiRad;
    end
    // Round to Q13 radians and to 1/128 degree wrapped to [0, 360).
    yaw = (z + 1024) >>> 11;
    zz = (z < 0) ? z + 2 * PiRad : z;
    head = (zz * HeadPerPi + PiRad / 2) / PiRad;
    if (head >= HeadWrap) begin
      head = head - HeadWrap;
    end
    res.yaw_radians = yaw[YawW-1:0];
    res.heading_degrees = head[HeadW-1:0];
    return res;
  endfunction

  function automatic in_t make_report(logic [IdW-1:0] id, int qi, int qj, int qk, int qr);
    in_t rpt;
    rpt.report_id = id;
    rpt.quat_i = QuatW'(qi);
    rpt.quat_j = QuatW'(qj);
    rpt.quat_k = QuatW'(qk);
    rpt.quat_real = QuatW'(qr);
    return rpt;
  endfunction

  // One quaternion component: full range, small magnitude, or an edge value.
  function automatic int random_component();
    int unsigned pick;
    int          val;
    pick = $urandom_range(99);
    if (pick < 50) begin
      val = int'($signed(16'($urandom)));
    end else if (pick < 80) begin
      val = int'($signed(16'($urandom))) >>> $urandom_range(15);
    end else begin
      case ($urandom_range(6))
        0: val = -32768;
        1: val = 32767;
        2: val = 0;
        3: val = 1;
        4: val = -1;
        5: val = 16384;
        default: val = -16384;
      endcase
    end
    return val;
  endfunction

  // Mostly rotation reports; the rest carry any id at all.
  function automatic in_t random_report();
    logic [IdW-1:0] id;
    id = ($urandom_range(99) < 85) ? RotationReport : IdW'($urandom);
    return make_report(id, random_component(), random_component(),
                       random_component(), random_component());
  endfunction

  // Drive one report transaction and wait until it is accepted.
  task automatic send_report(in_t rpt);
    bit accepted;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = rpt;
    accepted = 1'b0;
    while (!accepted) begin
      @(posedge clk_i);
      accepted = in_ready_o;
    end
    if (rpt.report_id == RotationReport) begin
      expected_results.push_back(yaw_heading_of(rpt));
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Wait until every expected result has come, then let the pipeline empty.
  task automatic wait_drained();
    while (expected_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (Latency + 4) @(negedge clk_i);
  endtask

  task automatic run_random(int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      send_report(random_report());
    end
  endtask

  // Field extremes, ignored ids, the zero vector, angles at pi and the
  // heading that rounds up to a full turn.
  task automatic test_directed();
    send_report(make_report(RotationReport, 0, 0, 0, 0));
    send_report(make_report(8'h00, 100, -200, 300, 16384));
    send_report(make_report(8'hFF, -32768, 32767, -32768, 32767));
    send_report(make_report(8'h07, 1, 2, 3, 4));
    send_report(make_report(8'h09, 1, 2, 3, 4));
    send_report(make_report(RotationReport, 0, 0, 0, 16384));
    send_report(make_report(RotationReport, 0, 0, 0, -16384));
    send_report(make_report(RotationReport, 0, 0, 16384, 0));
    send_report(make_report(RotationReport, 0, 0, 16384, 16384));
    send_report(make_report(RotationReport, 0, 0, -16384, 16384));
    send_report(make_report(RotationReport, 1, -1, 0, 32767));
    send_report(make_report(RotationReport, 1, -1, 16384, 0));
    send_report(make_report(RotationReport, 1, 1, 16384, 0));
    send_report(make_report(RotationReport, -32768, -32768, -32768, -32768));
    send_report(make_report(RotationReport, 32767, 32767, 32767, 32767));
    send_report(make_report(RotationReport, -32768, 32767, -32768, 32767));
    send_report(make_report(RotationReport, 32767, -32768, 32767, -32768));
    send_report(make_report(RotationReport, 1, 0, 0, 0));
    send_report(make_report(RotationReport, 0, 1, 0, 0));
    send_report(make_report(RotationReport, 1, 1, 0, 0));
    send_report(make_report(RotationReport, 0, 0, 32767, -32768));
    send_report(make_report(RotationReport, -1, 0, 0, 0));
    wait_drained();
  endtask

  task automatic test_no_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(PhaseItems);
  endtask

  task automatic test_sender_idle();
    send_idle_pct = 63;
    recv_stall_pct = 0;
    run_random(PhaseItems);
  endtask

  task automatic test_receiver_stall();
    send_idle_pct = 0;
    recv_stall_pct = 63;
    run_random(PhaseItems);
  endtask

  // Both sides idle, with a full drain halfway through.
  task automatic test_both_idle_with_drain();
    send_idle_pct = 30;
    recv_stall_pct = 30;
    run_random(PhaseItems / 2);
    wait_drained();
    run_random(PhaseItems / 2);
  endtask

  // Receiver readiness, changed at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready_i = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports) begin
          $display("unexpected result: yaw %0d heading %0d",
                   out_data_o.yaw_radians, out_data_o.heading_degrees);
        end
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.yaw_radians !== want.yaw_radians ||
            out_data_o.heading_degrees !== want.heading_degrees) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports) begin
            $display("mismatch: expected yaw %0d heading %0d, got yaw %0d heading %0d",
                     want.yaw_radians, want.heading_degrees,
                     out_data_o.yaw_radians, out_data_o.heading_degrees);
          end
        end
      end
    end
  end

  // End the run when no transaction moves on either side for too long.
  always @(posedge clk_i) begin
    if (watchdog_on) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IdleLimit) begin
        $display("FAIL quaternion_to_yaw_heading_top");
        $finish;
      end
    end
  end

  // Reset, then the tests in turn, then the final check.
  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    quiet_cycles = 0;
    watchdog_on = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    watchdog_on = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle_with_drain();

    while (expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (Latency + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS quaternion_to_yaw_heading_top");
    end else begin
      $display("FAIL quaternion_to_yaw_heading_top");
    end
    $finish;
  end

endmodule
